// File: rtl/multi_slot_event_timer_table_assert.svh
// Assertion macros for the timer table.
`ifndef MULTI_SLOT_EVENT_TIMER_TABLE_ASSERT_SVH
`define MULTI_SLOT_EVENT_TIMER_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define MSETT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MSETT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MSETT_ASSERT_IMPL(label, clk, rst, ante, cons)
`define MSETT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/mset_pkg.sv
`default_nettype none
package mset_pkg;
  localparam int SLOTS = 16;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int TICK_W = 16;

  localparam logic [3:0] OP_TICK = 4'd0;
  localparam logic [3:0] OP_NEW_PER = 4'd1;
  localparam logic [3:0] OP_NEW_ONE = 4'd2;
  localparam logic [3:0] OP_NEW_OFS = 4'd3;
  localparam logic [3:0] OP_UPD_NEW = 4'd4;
  localparam logic [3:0] OP_UPD = 4'd5;
  localparam logic [3:0] OP_FREE = 4'd6;
  localparam logic [3:0] OP_FREE_ALL = 4'd7;
  localparam logic [3:0] OP_PAUSE = 4'd8;
  localparam logic [3:0] OP_RESUME = 4'd9;
  localparam logic [3:0] OP_RES_NEW = 4'd10;
  localparam logic [3:0] OP_FREE_FN = 4'd11;

  localparam logic [1:0] KIND_EXP = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ACK = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOMATCH = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic load;
    logic start;
    logic step;
  } mset_cmd_t;

  typedef struct packed {
    logic last_slot;
    logic valid;
    logic enabled;
    logic matched;
    logic fn_match;
    logic tgt_fn_match;
    logic count_zero;
    logic reload_zero;
  } mset_stat_t;
endpackage
`default_nettype wire

// File: rtl/mset_datapath.sv
`default_nettype none
module mset_datapath (
  input  wire logic clk,
  input  wire logic rst,
  input  wire mset_pkg::mset_cmd_t cmd,
  input  wire logic [3:0] opcode,
  input  wire logic [7:0] target_id,
  input  wire logic [7:0] event_code,
  input  wire logic is_function,
  input  wire logic [15:0] first_ticks,
  input  wire logic [15:0] period_ticks,
  input  wire logic wr_load,
  input  wire logic [1:0] wr_reload_sel,
  input  wire logic wr_free,
  input  wire logic wr_set_en,
  input  wire logic wr_clr_en,
  input  wire logic tick_dec,
  input  wire logic tick_reload,
  input  wire logic [mset_pkg::IDX_W-1:0] wr_idx,
  output mset_pkg::mset_stat_t stat,
  output logic [mset_pkg::IDX_W-1:0] cur_idx,
  output logic [3:0] q_op,
  output logic [7:0] cur_target,
  output logic [7:0] cur_event,
  output logic cur_function
);
  logic [mset_pkg::SLOTS-1:0] valid;
  logic [mset_pkg::SLOTS-1:0] enabled;
  logic [mset_pkg::SLOTS-1:0] fn_mem;
  logic [7:0] tgt_mem [mset_pkg::SLOTS];
  logic [7:0] ev_mem [mset_pkg::SLOTS];
  logic [mset_pkg::TICK_W-1:0] rel_mem [mset_pkg::SLOTS];
  logic [mset_pkg::TICK_W-1:0] cnt_mem [mset_pkg::SLOTS];
  logic [7:0] q_tgt;
  logic [7:0] q_ev;
  logic q_fn;
  logic [mset_pkg::TICK_W-1:0] q_first;
  logic [mset_pkg::TICK_W-1:0] q_period;
  logic [mset_pkg::TICK_W-1:0] cur_count;
  logic [mset_pkg::TICK_W-1:0] cur_reload;
  logic [mset_pkg::TICK_W-1:0] rel_val;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_op <= opcode;
      q_tgt <= target_id;
      q_ev <= event_code;
      q_fn <= is_function;
      q_first <= (first_ticks != '0) ? first_ticks - 1'b1 : '0;
      q_period <= (period_ticks != '0) ? period_ticks - 1'b1 : '0;
    end
    if (cmd.start) begin
      cur_idx <= '0;
    end else if (cmd.step) begin
      cur_idx <= cur_idx + 1'b1;
    end
  end

  assign cur_target = tgt_mem[cur_idx];
  assign cur_event = ev_mem[cur_idx];
  assign cur_function = fn_mem[cur_idx];
  assign cur_count = cnt_mem[cur_idx];
  assign cur_reload = rel_mem[cur_idx];

  always_comb begin
    stat.last_slot = (cur_idx == mset_pkg::IDX_W'(mset_pkg::SLOTS - 1));
    stat.valid = valid[cur_idx];
    stat.enabled = enabled[cur_idx];
    stat.tgt_fn_match = valid[cur_idx] && cur_target == q_tgt && cur_function == q_fn;
    stat.matched = stat.tgt_fn_match && (q_fn || cur_event == q_ev);
    stat.fn_match = valid[cur_idx] && cur_function && cur_target == q_tgt;
    stat.count_zero = (cur_count == '0);
    stat.reload_zero = (cur_reload == '0);
    case (wr_reload_sel)
      2'd0: rel_val = q_first;
      2'd1: rel_val = '0;
      default: rel_val = q_period;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_load) begin
      fn_mem[wr_idx] <= q_fn;
      tgt_mem[wr_idx] <= q_tgt;
      ev_mem[wr_idx] <= q_fn ? 8'd0 : q_ev;
      cnt_mem[wr_idx] <= q_first;
      rel_mem[wr_idx] <= rel_val;
    end else if (tick_dec) begin
      cnt_mem[cur_idx] <= cur_count - 1'b1;
    end else if (tick_reload) begin
      cnt_mem[cur_idx] <= cur_reload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      enabled <= '0;
    end else begin
      if (wr_load) begin
        valid[wr_idx] <= 1'b1;
        enabled[wr_idx] <= 1'b1;
      end
      if (wr_free) begin
        valid[wr_idx] <= 1'b0;
      end
      if (wr_set_en) begin
        enabled[wr_idx] <= 1'b1;
      end
      if (wr_clr_en) begin
        enabled[wr_idx] <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/mset_ctrl.sv
`default_nettype none
module mset_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [1:0] result_kind,
  output logic [4:0] slot_index,
  output logic [7:0] out_target,
  output logic [7:0] out_event,
  output logic out_is_function,
  output logic [1:0] status,
  output logic last,
  output mset_pkg::mset_cmd_t cmd,
  input  wire mset_pkg::mset_stat_t stat,
  input  wire logic [mset_pkg::IDX_W-1:0] cur_idx,
  input  wire logic [3:0] q_op,
  input  wire logic [7:0] cur_target,
  input  wire logic [7:0] cur_event,
  input  wire logic cur_function,
  output logic wr_load,
  output logic [1:0] wr_reload_sel,
  output logic wr_free,
  output logic wr_set_en,
  output logic wr_clr_en,
  output logic tick_dec,
  output logic tick_reload,
  output logic [mset_pkg::IDX_W-1:0] wr_idx
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_ACT = 4'b0100,
    S_OUT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic found_m;
  logic [mset_pkg::IDX_W-1:0] idx_m;
  logic found_f;
  logic [mset_pkg::IDX_W-1:0] idx_f;
  logic tick_op;
  logic need_match;
  logic want_free;
  logic emit_exp;
  logic exp_pending;
  logic [mset_pkg::IDX_W-1:0] act_idx;
  logic [1:0] act_st;
  logic act_hit;
  logic out_busy;

  assign tick_op = (q_op == mset_pkg::OP_TICK);
  assign need_match = (q_op == mset_pkg::OP_UPD_NEW) || (q_op == mset_pkg::OP_UPD)
      || (q_op == mset_pkg::OP_FREE) || (q_op == mset_pkg::OP_PAUSE)
      || (q_op == mset_pkg::OP_RESUME) || (q_op == mset_pkg::OP_RES_NEW);
  assign want_free = (q_op == mset_pkg::OP_NEW_PER) || (q_op == mset_pkg::OP_NEW_ONE)
      || (q_op == mset_pkg::OP_NEW_OFS) || (q_op == mset_pkg::OP_UPD_NEW)
      || (q_op == mset_pkg::OP_RES_NEW);
  assign out_busy = out_valid && !out_ready;
  assign in_ready = (state == S_IDLE) && !out_busy;
  assign emit_exp = (state == S_SCAN) && tick_op && stat.valid && stat.enabled
      && stat.count_zero;
  assign exp_pending = emit_exp;

  always_comb begin
    state_next = state;
    cmd = '0;
    wr_load = 1'b0;
    wr_reload_sel = 2'd0;
    wr_free = 1'b0;
    wr_set_en = 1'b0;
    wr_clr_en = 1'b0;
    tick_dec = 1'b0;
    tick_reload = 1'b0;
    wr_idx = cur_idx;
    act_hit = 1'b0;
    act_st = mset_pkg::ST_OK;
    act_idx = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          cmd.start = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tick_op) begin
          if (!(emit_exp && out_busy)) begin
            if (stat.valid && stat.enabled) begin
              if (stat.count_zero) begin
                tick_reload = 1'b1;
                wr_free = stat.reload_zero;
              end else begin
                tick_dec = 1'b1;
              end
            end
            cmd.step = 1'b1;
            if (stat.last_slot) begin
              state_next = S_OUT;
            end
          end
        end else if (q_op == mset_pkg::OP_FREE_ALL) begin
          wr_free = stat.tgt_fn_match;
          cmd.step = 1'b1;
          if (stat.last_slot) begin
            state_next = S_OUT;
          end
        end else begin
          cmd.step = 1'b1;
          if (stat.last_slot) begin
            state_next = S_ACT;
          end
        end
      end
      S_ACT: begin
        state_next = S_OUT;
        if (want_free || need_match || q_op == mset_pkg::OP_FREE_FN) begin
          if (need_match && found_m) begin
            wr_idx = idx_m;
            if (q_op == mset_pkg::OP_FREE) begin
              wr_free = 1'b1;
            end else if (q_op == mset_pkg::OP_PAUSE) begin
              wr_clr_en = 1'b1;
            end else if (q_op == mset_pkg::OP_RESUME || q_op == mset_pkg::OP_RES_NEW) begin
              wr_set_en = 1'b1;
            end else begin
              wr_load = 1'b1;
              wr_reload_sel = 2'd0;
            end
          end else if (q_op == mset_pkg::OP_FREE_FN) begin
            wr_idx = idx_m;
            wr_free = found_m;
          end else if (want_free && found_f) begin
            wr_idx = idx_f;
            wr_load = 1'b1;
            if (q_op == mset_pkg::OP_NEW_ONE || q_op == mset_pkg::OP_UPD_NEW) begin
              wr_reload_sel = 2'd1;
            end else if (q_op == mset_pkg::OP_NEW_OFS) begin
              wr_reload_sel = 2'd2;
            end else begin
              wr_reload_sel = 2'd0;
            end
          end
        end
      end
      S_OUT: begin
        if (!out_busy) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    act_hit = 1'b0;
    if (need_match && found_m) begin
      act_idx = idx_m;
      act_hit = 1'b1;
    end else if (q_op == mset_pkg::OP_FREE_FN) begin
      act_idx = idx_m;
      act_hit = found_m;
      act_st = found_m ? mset_pkg::ST_OK : mset_pkg::ST_NOMATCH;
    end else if (want_free) begin
      act_idx = idx_f;
      act_hit = found_f;
      act_st = found_f ? mset_pkg::ST_OK : mset_pkg::ST_FULL;
    end else if (need_match) begin
      act_st = mset_pkg::ST_NOMATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_SCAN && emit_exp && !out_busy) begin
        out_valid <= 1'b1;
      end
      if (state == S_SCAN && tick_op && stat.last_slot && !(emit_exp && out_busy)) begin
        out_valid <= exp_pending || out_valid && !out_ready;
      end
      if (state == S_OUT && !out_busy) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SCAN && emit_exp && !out_busy) begin
      result_kind <= mset_pkg::KIND_EXP;
      slot_index <= 5'(cur_idx);
      out_target <= cur_target;
      out_event <= cur_event;
      out_is_function <= cur_function;
      status <= mset_pkg::ST_OK;
      last <= 1'b0;
    end
    if (state == S_OUT && !out_busy) begin
      out_target <= '0;
      out_event <= '0;
      out_is_function <= 1'b0;
      last <= 1'b1;
      if (tick_op) begin
        result_kind <= mset_pkg::KIND_DONE;
        slot_index <= 5'(mset_pkg::SLOTS);
        status <= mset_pkg::ST_OK;
      end else if (q_op == mset_pkg::OP_FREE_ALL) begin
        result_kind <= mset_pkg::KIND_ACK;
        slot_index <= found_m ? 5'(idx_m) : 5'(mset_pkg::SLOTS);
        status <= found_m ? mset_pkg::ST_OK : mset_pkg::ST_NOMATCH;
      end else begin
        result_kind <= mset_pkg::KIND_ACK;
        slot_index <= act_hit ? 5'(act_idx) : 5'(mset_pkg::SLOTS);
        status <= act_st;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      found_m <= 1'b0;
      found_f <= 1'b0;
      idx_m <= '0;
      idx_f <= '0;
    end else if (state == S_SCAN && cmd.step) begin
      if (!found_m && ((q_op == mset_pkg::OP_FREE_FN) ? stat.fn_match
          : (q_op == mset_pkg::OP_FREE_ALL) ? stat.tgt_fn_match : stat.matched)) begin
        found_m <= 1'b1;
        idx_m <= cur_idx;
      end
      if (!found_f && !stat.valid) begin
        found_f <= 1'b1;
        idx_f <= cur_idx;
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/multi_slot_event_timer_table.sv
`default_nettype none
// A sixteen-slot timer table. Every request walks all slots once, one slot per clock
// unless held as below. A command then applies its change in S_ACT and posts the
// acknowledge from S_OUT; a free-all frees during the walk and skips S_ACT. A tick
// ends with a done marker, and an expiry met while a notice waits holds the walk.
`include "multi_slot_event_timer_table_assert.svh"
module multi_slot_event_timer_table (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [3:0] opcode,
  input  wire logic [7:0] target_id,
  input  wire logic [7:0] event_code,
  input  wire logic is_function,
  input  wire logic [15:0] first_ticks,
  input  wire logic [15:0] period_ticks,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [1:0] result_kind,
  output logic [4:0] slot_index,
  output logic [7:0] out_target,
  output logic [7:0] out_event,
  output logic out_is_function,
  output logic [1:0] status,
  output logic last
);
  mset_pkg::mset_cmd_t cmd;
  mset_pkg::mset_stat_t stat;
  logic [mset_pkg::IDX_W-1:0] cur_idx;
  logic [mset_pkg::IDX_W-1:0] wr_idx;
  logic [3:0] q_op;
  logic [7:0] cur_target;
  logic [7:0] cur_event;
  logic cur_function;
  logic wr_load;
  logic [1:0] wr_reload_sel;
  logic wr_free;
  logic wr_set_en;
  logic wr_clr_en;
  logic tick_dec;
  logic tick_reload;

  mset_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .result_kind, .slot_index, .out_target, .out_event, .out_is_function,
    .status, .last, .cmd, .stat, .cur_idx, .q_op, .cur_target, .cur_event,
    .cur_function, .wr_load, .wr_reload_sel, .wr_free, .wr_set_en, .wr_clr_en,
    .tick_dec, .tick_reload, .wr_idx
  );

  mset_datapath u_dp (
    .clk, .rst, .cmd, .opcode, .target_id, .event_code, .is_function,
    .first_ticks, .period_ticks, .wr_load, .wr_reload_sel, .wr_free,
    .wr_set_en, .wr_clr_en, .tick_dec, .tick_reload, .wr_idx, .stat,
    .cur_idx, .q_op, .cur_target, .cur_event, .cur_function
  );

  `MSETT_ASSERT_IMPL(a_no_accept_busy, clk, rst, in_ready, !(out_valid && !out_ready))
  `MSETT_ASSERT_IMPL(a_exp_not_last, clk, rst, out_valid && result_kind == mset_pkg::KIND_EXP,
      !last)
  `MSETT_ASSERT_NEXT(a_load_start, clk, rst, in_valid && in_ready, !in_ready)
endmodule
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none

typedef struct packed {
  logic [1:0] kind;
  logic [4:0] idx;
  logic [7:0] tgt;
  logic [7:0] ev;
  logic       fn;
  logic [1:0] st;
  logic       lst;
} timer_result_t;

class timer_scoreboard;
  bit          valid_q [mset_pkg::SLOTS];
  bit          enabled_q [mset_pkg::SLOTS];
  bit          fn_q [mset_pkg::SLOTS];
  logic [7:0]  tgt_q [mset_pkg::SLOTS];
  logic [7:0]  ev_q [mset_pkg::SLOTS];
  logic [15:0] reload_q [mset_pkg::SLOTS];
  logic [15:0] count_q [mset_pkg::SLOTS];
  timer_result_t pending_results[$];
  int errors;
  int results_seen;
  int expiries_seen;

  function new();
    errors = 0;
    results_seen = 0;
    expiries_seen = 0;
    for (int i = 0; i < mset_pkg::SLOTS; i++) begin
      valid_q[i] = 0;
      enabled_q[i] = 0;
    end
  endfunction

  function int free_slot();
    for (int i = 0; i < mset_pkg::SLOTS; i++) begin
      if (!valid_q[i]) return i;
    end
    return mset_pkg::SLOTS;
  endfunction

  function int match_slot(logic [7:0] t, logic [7:0] e, bit f);
    for (int i = 0; i < mset_pkg::SLOTS; i++) begin
      if (valid_q[i] && tgt_q[i] == t && fn_q[i] == f && (f || ev_q[i] == e)) return i;
    end
    return mset_pkg::SLOTS;
  endfunction

  function void fill(int i, logic [7:0] t, logic [7:0] e, bit f, logic [15:0] c,
                     logic [15:0] r);
    valid_q[i] = 1;
    enabled_q[i] = 1;
    fn_q[i] = f;
    tgt_q[i] = t;
    ev_q[i] = f ? 8'd0 : e;
    count_q[i] = c;
    reload_q[i] = r;
  endfunction

  function void push(logic [1:0] k, int i, logic [7:0] t, logic [7:0] e, bit f,
                     logic [1:0] s, bit l);
    timer_result_t r;
    r.kind = k;
    r.idx = i[4:0];
    r.tgt = t;
    r.ev = e;
    r.fn = f;
    r.st = s;
    r.lst = l;
    pending_results.push_back(r);
  endfunction

  function void note_request(logic [3:0] op, logic [7:0] t, logic [7:0] e, bit f,
                             logic [15:0] ft, logic [15:0] pt);
    logic [15:0] first;
    logic [15:0] period;
    int idx;
    logic [1:0] st;
    first = (ft != 0) ? ft - 16'd1 : 16'd0;
    period = (pt != 0) ? pt - 16'd1 : 16'd0;
    idx = mset_pkg::SLOTS;
    st = mset_pkg::ST_OK;
    if (op == mset_pkg::OP_TICK) begin
      for (int i = 0; i < mset_pkg::SLOTS; i++) begin
        if (valid_q[i] && enabled_q[i]) begin
          if (count_q[i] == 0) begin
            push(mset_pkg::KIND_EXP, i, tgt_q[i], ev_q[i], fn_q[i], mset_pkg::ST_OK, 0);
            count_q[i] = reload_q[i];
            if (reload_q[i] == 0) valid_q[i] = 0;
          end else begin
            count_q[i] = count_q[i] - 16'd1;
          end
        end
      end
      push(mset_pkg::KIND_DONE, mset_pkg::SLOTS, 0, 0, 0, mset_pkg::ST_OK, 1);
      return;
    end
    case (op)
      mset_pkg::OP_NEW_PER, mset_pkg::OP_NEW_ONE, mset_pkg::OP_NEW_OFS: begin
        idx = free_slot();
        if (idx < mset_pkg::SLOTS) begin
          fill(idx, t, e, f, first, op == mset_pkg::OP_NEW_PER ? first :
               (op == mset_pkg::OP_NEW_ONE ? 16'd0 : period));
        end else begin
          st = mset_pkg::ST_FULL;
        end
      end
      mset_pkg::OP_UPD_NEW, mset_pkg::OP_UPD: begin
        idx = match_slot(t, e, f);
        if (idx < mset_pkg::SLOTS) begin
          fill(idx, t, e, f, first, first);
        end else if (op == mset_pkg::OP_UPD_NEW) begin
          idx = free_slot();
          if (idx < mset_pkg::SLOTS) fill(idx, t, e, f, first, 16'd0);
          else st = mset_pkg::ST_FULL;
        end else begin
          st = mset_pkg::ST_NOMATCH;
        end
      end
      mset_pkg::OP_FREE, mset_pkg::OP_PAUSE, mset_pkg::OP_RESUME,
      mset_pkg::OP_RES_NEW: begin
        idx = match_slot(t, e, f);
        if (idx < mset_pkg::SLOTS) begin
          if (op == mset_pkg::OP_FREE) valid_q[idx] = 0;
          else enabled_q[idx] = (op != mset_pkg::OP_PAUSE);
        end else if (op == mset_pkg::OP_RES_NEW) begin
          idx = free_slot();
          if (idx < mset_pkg::SLOTS) fill(idx, t, e, f, first, first);
          else st = mset_pkg::ST_FULL;
        end else begin
          st = mset_pkg::ST_NOMATCH;
        end
      end
      mset_pkg::OP_FREE_ALL: begin
        for (int i = mset_pkg::SLOTS - 1; i >= 0; i--) begin
          if (valid_q[i] && tgt_q[i] == t && fn_q[i] == f) begin
            valid_q[i] = 0;
            idx = i;
          end
        end
        if (idx >= mset_pkg::SLOTS) st = mset_pkg::ST_NOMATCH;
      end
      mset_pkg::OP_FREE_FN: begin
        for (int i = mset_pkg::SLOTS - 1; i >= 0; i--) begin
          if (valid_q[i] && fn_q[i] && tgt_q[i] == t) idx = i;
        end
        if (idx < mset_pkg::SLOTS) valid_q[idx] = 0;
        else st = mset_pkg::ST_NOMATCH;
      end
      default: ;
    endcase
    push(mset_pkg::KIND_ACK, idx, 0, 0, 0, st, 1);
  endfunction

  function void check_result(timer_result_t got);
    timer_result_t want;
    results_seen++;
    if (got.kind == mset_pkg::KIND_EXP) expiries_seen++;
    if (pending_results.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %h", got);
      return;
    end
    want = pending_results.pop_front();
    if (got !== want) begin
      errors++;
      if (errors <= 10) begin
        $display("mismatch: kind %0d/%0d slot %0d/%0d tgt %0h/%0h ev %0h/%0h",
                 want.kind, got.kind, want.idx, got.idx, want.tgt, got.tgt,
                 want.ev, got.ev);
        $display("  fn %0d/%0d status %0d/%0d last %0d/%0d (expected/actual)",
                 want.fn, got.fn, want.st, got.st, want.lst, got.lst);
      end
    end
  endfunction
endclass

module tb_top;
  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [3:0] opcode;
  logic [7:0] target_id;
  logic [7:0] event_code;
  logic is_function;
  logic [15:0] first_ticks;
  logic [15:0] period_ticks;
  logic out_valid;
  logic out_ready;
  logic [1:0] result_kind;
  logic [4:0] slot_index;
  logic [7:0] out_target;
  logic [7:0] out_event;
  logic out_is_function;
  logic [1:0] status;
  logic last;

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off;
  bit stim_done;
  int cycles;
  int items_sent;
  timer_scoreboard sb;

  multi_slot_event_timer_table u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .target_id(target_id), .event_code(event_code),
    .is_function(is_function), .first_ticks(first_ticks),
    .period_ticks(period_ticks), .out_valid(out_valid), .out_ready(out_ready),
    .result_kind(result_kind), .slot_index(slot_index), .out_target(out_target),
    .out_event(out_event), .out_is_function(out_is_function), .status(status),
    .last(last)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    sb = new();
    cycles = 0;
    in_valid = 0;
    opcode = 0;
    target_id = 0;
    event_code = 0;
    is_function = 0;
    first_ticks = 0;
    period_ticks = 0;
    out_ready = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 0;
    stim_done = 0;
    items_sent = 0;
    rst = 1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("timeout");
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result({result_kind, slot_index, out_target, out_event,
                       out_is_function, status, last});
    end
  end

  always @(negedge clk) begin
    if (rst || hold_off) out_ready <= 0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_request(logic [3:0] op, logic [7:0] t, logic [7:0] e, bit f,
                              logic [15:0] ft, logic [15:0] pt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    opcode <= op;
    target_id <= t;
    event_code <= e;
    is_function <= f;
    first_ticks <= ft;
    period_ticks <= pt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(op, t, e, f, ft, pt);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_random();
    int r;
    logic [3:0] op;
    logic [15:0] ft;
    logic [15:0] pt;
    logic [7:0] t;
    logic [7:0] e;
    r = $urandom_range(99);
    if (r < 30) op = mset_pkg::OP_TICK;
    else if (r < 95) op = 4'($urandom_range(11, 1));
    else op = 4'($urandom_range(15, 12));
    t = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    e = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    ft = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(4));
    pt = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(4));
    send_request(op, t, e, 1'($urandom_range(1)), ft, pt);
  endtask

  task automatic drain();
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    send_request(mset_pkg::OP_NEW_PER, 8'hFF, 8'hFF, 0, 16'd0, 16'hFFFF);
    send_request(mset_pkg::OP_NEW_ONE, 8'h00, 8'h00, 1, 16'd1, 16'd0);
    send_request(mset_pkg::OP_NEW_OFS, 8'hAA, 8'h55, 0, 16'd2, 16'd3);
    send_request(mset_pkg::OP_NEW_PER, 8'h55, 8'hAA, 0, 16'hFFFF, 16'hFFFF);
    send_request(mset_pkg::OP_TICK, 0, 0, 0, 0, 0);
    send_request(mset_pkg::OP_TICK, 0, 0, 0, 0, 0);
    send_request(mset_pkg::OP_UPD, 8'hAA, 8'h55, 0, 16'd1, 0);
    send_request(mset_pkg::OP_UPD, 8'h12, 8'h34, 0, 16'd1, 0);
    send_request(mset_pkg::OP_UPD_NEW, 8'h12, 8'h34, 1, 16'd3, 0);
    send_request(mset_pkg::OP_PAUSE, 8'hAA, 8'h55, 0, 0, 0);
    send_request(mset_pkg::OP_TICK, 0, 0, 0, 0, 0);
    send_request(mset_pkg::OP_RESUME, 8'hAA, 8'h55, 0, 0, 0);
    send_request(mset_pkg::OP_RESUME, 8'h77, 8'h55, 0, 0, 0);
    send_request(mset_pkg::OP_RES_NEW, 8'h77, 8'h01, 0, 16'd2, 0);
    send_request(mset_pkg::OP_FREE, 8'h77, 8'h01, 0, 0, 0);
    send_request(mset_pkg::OP_FREE_FN, 8'h12, 0, 0, 0, 0);
    send_request(mset_pkg::OP_FREE_FN, 8'h99, 0, 0, 0, 0);
    for (int i = 0; i < 15; i++) begin
      send_request(mset_pkg::OP_NEW_ONE, 8'h03, i[7:0], 0, 16'd9, 0);
    end
    send_request(mset_pkg::OP_UPD_NEW, 8'h04, 0, 0, 16'd1, 0);
    send_request(mset_pkg::OP_RES_NEW, 8'h04, 1, 0, 16'd1, 0);
    send_request(mset_pkg::OP_FREE_ALL, 8'h03, 0, 0, 0, 0);
    send_request(mset_pkg::OP_FREE_ALL, 8'h03, 0, 0, 0, 0);
    send_request(4'd12, 0, 0, 0, 0, 0);
    send_request(4'd15, 8'hFF, 8'hFF, 1, 16'hFFFF, 16'hFFFF);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 77 : 29) : 0;
      recv_stall_pct = (ph == 2) ? 77 : ((ph == 3) ? 29 : 0);
      for (int n = 0; n < 80; n++) send_random();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      begin
        for (int n = 0; n < 15; n++) send_random();
        in_valid <= 0;
      end
    join
    stim_done = 1;
    drain();
    $display("Sent %0d requests across four idle/stall mixes and a long output stall;",
             items_sent);
    $display("checked %0d results, %0d of them expiry notices.", sb.results_seen,
             sb.expiries_seen);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("errors %0d, still expected %0d", sb.errors, sb.pending_results.size());
      $display("status: fail");
    end
    $finish;
  end
endmodule

`default_nettype wire
